@@ design/dqrb_pkg.sv @@
// shared types, constants and small functions of the dead-zone quantizer block
// no dependencies; imported by the front end, queue, back end and top level
package dqrb_pkg;

  // block geometry (4x4 coefficients, raster order)
  localparam int BLOCK_LEN = 16;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;

  // accumulator and datapath widths
  localparam int COEF_W  = 16;
  localparam int BITS_W  = 9;
  localparam int RATE_W  = 10;
  localparam int COST_W  = 26;
  localparam int GAIN_W  = 36;
  localparam int OUT_GAIN_W = 32;
  localparam int TOTAL_CNT_W = 24;

  localparam logic signed [31:0] ROUND_HALF = 32'sd32768;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_QUANT_STEP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_STEP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LAMBDA       = 2'd3;

  typedef struct packed {
    logic [14:0] quant_step;
    logic [14:0] inverse_step;
    logic [13:0] dead_zone;
    logic [15:0] lambda;
  } dqrb_cfg_t;

  // one classified coefficient as it waits in the queue
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [COEF_W-1:0] q;
    logic                     zeroed;
  } dqrb_item_t;

  // side-information cost by number of nonzero coefficients
  function automatic logic [5:0] count_bits(input logic [CNT_W-1:0] cnt);
    logic [5:0] r;
    case (cnt)
      5'd0:  r = 6'd8;
      5'd1:  r = 6'd16;
      5'd2:  r = 6'd22;
      5'd3:  r = 6'd26;
      5'd4:  r = 6'd30;
      5'd5:  r = 6'd32;
      5'd6:  r = 6'd34;
      5'd7:  r = 6'd35;
      5'd8:  r = 6'd35;
      5'd9:  r = 6'd35;
      5'd10: r = 6'd34;
      5'd11: r = 6'd32;
      5'd12: r = 6'd30;
      5'd13: r = 6'd26;
      5'd14: r = 6'd22;
      5'd15: r = 6'd16;
      5'd16: r = 6'd8;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // position of the highest set bit plus one
  function automatic logic [4:0] bit_length(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ design/dqrb_front.sv @@
// front end: takes coefficients, applies the dead zone and quantizes
// depends on dqrb_pkg; feeds dqrb_queue
module dqrb_front (
  input  logic                              coef_valid,
  output logic                              coef_stall,
  input  logic signed [15:0]                coefficient,
  input  dqrb_pkg::dqrb_cfg_t               cfg,
  input  logic                              queue_full,
  output logic                              push,
  output dqrb_pkg::dqrb_item_t              item
);
  import dqrb_pkg::*;

  logic signed [16:0] thr;
  logic signed [16:0] coef_ext;
  logic signed [31:0] prod;
  logic signed [31:0] rounded;
  logic               in_zone;

  assign coef_stall = queue_full;
  assign push       = coef_valid && !queue_full;

  assign thr      = signed'({3'b000, cfg.dead_zone});
  assign coef_ext = 17'(coefficient);
  assign in_zone  = (coef_ext >= -thr) && (coef_ext <= thr);

  // floor((x * inverse_step + half) / 65536) is the upper half of the sum
  assign prod    = 32'(coefficient) * signed'({17'd0, cfg.inverse_step});
  assign rounded = prod + ROUND_HALF;

  assign item.coef   = coefficient;
  assign item.q      = signed'(rounded[31:16]);
  assign item.zeroed = in_zone;
endmodule

@@ design/dqrb_queue.sv @@
// small register queue between the front end and the back end
// depends on dqrb_pkg for the item type
module dqrb_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dqrb_pkg::dqrb_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output dqrb_pkg::dqrb_item_t head
);
  import dqrb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  dqrb_item_t         entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W_Q-1:0] count;

  assign full      = (count == CNT_W_Q'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end
endmodule

@@ design/dqrb_back.sv @@
// back end: error, gain and rate accumulation, block decision, result register
// depends on dqrb_pkg; drains dqrb_queue
module dqrb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  dqrb_pkg::dqrb_cfg_t  cfg,
  input  logic                 item_ready,
  input  dqrb_pkg::dqrb_item_t item,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [15:0]          code,
  output logic                 block_end,
  output logic [31:0]          block_gain,
  output logic                 significant,
  output logic [14:0]          running_max,
  output logic signed [15:0]   running_min,
  output logic [23:0]          running_count
);
  import dqrb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ERR    = 6'b000010,
    ST_SQ     = 6'b000100,
    ST_COST   = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_EMIT   = 6'b100000
  } back_state_t;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_LEN - 1);

  back_state_t state;

  // per-block state and running totals
  logic [POS_W-1:0]         position;
  logic signed [GAIN_W-1:0] gain_acc;
  logic [BITS_W-1:0]        bits_acc;
  logic [CNT_W-1:0]         nonzero;
  logic signed [15:0]       block_max;
  logic signed [15:0]       block_min;
  logic signed [15:0]       total_max;
  logic signed [15:0]       total_min;
  logic [TOTAL_CNT_W-1:0]   total_count;

  // work registers of the item in flight
  dqrb_item_t               w_item;
  logic signed [15:0]       w_err;
  logic [15:0]              w_code;
  logic                     w_end;
  logic [RATE_W-1:0]        rate;
  logic [COST_W-1:0]        cost;
  logic [OUT_GAIN_W-1:0]    res_gain;
  logic                     res_sig;

  // datapath
  logic [30:0]              qmul;
  logic signed [15:0]       err_w;
  logic [15:0]              q_mag;
  logic [15:0]              code_w;
  logic signed [31:0]       sq_x;
  logic signed [31:0]       sq_e;
  logic signed [32:0]       sq_diff;
  logic [RATE_W-1:0]        rate_w;
  logic signed [GAIN_W-1:0] cost_ext;
  logic signed [GAIN_W-1:0] net;
  logic [TOTAL_CNT_W:0]     cnt_sum;
  logic                     emit_ok;

  assign pop     = (state == ST_IDLE) && item_ready;
  assign emit_ok = !result_valid || !result_stall;

  assign qmul   = $unsigned(w_item.q) * cfg.quant_step;
  assign err_w  = w_item.coef - signed'(qmul[15:0]);
  assign q_mag  = w_item.q[15] ? 16'(-w_item.q) : w_item.q;
  assign code_w = {q_mag[14:0], w_item.q[15]};

  assign sq_x    = 32'(w_item.coef) * 32'(w_item.coef);
  assign sq_e    = 32'(w_err) * 32'(w_err);
  assign sq_diff = 33'(sq_x) - 33'(sq_e);

  assign rate_w = RATE_W'({bits_acc + BITS_W'(nonzero), 1'b0})
                + RATE_W'(count_bits(nonzero));

  assign cost_ext = signed'({{(GAIN_W - COST_W){1'b0}}, cost});
  assign net      = gain_acc - cost_ext;
  assign cnt_sum  = {1'b0, total_count} + (TOTAL_CNT_W + 1)'(nonzero);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      position     <= '0;
      gain_acc     <= '0;
      bits_acc     <= '0;
      nonzero      <= '0;
      block_max    <= '0;
      block_min    <= '0;
      total_max    <= '0;
      total_min    <= '0;
      total_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      // emit state refills the register itself when the old result leaves
      if (result_valid && !result_stall && (state != ST_EMIT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_ready) state <= ST_ERR;
        end
        ST_ERR: begin
          if (!w_item.zeroed) begin
            bits_acc <= bits_acc + BITS_W'(bit_length(code_w));
            nonzero  <= nonzero + 1'b1;
            if (w_item.q > block_max) block_max <= w_item.q;
            if (w_item.q < block_min) block_min <= w_item.q;
          end
          state <= ST_SQ;
        end
        ST_SQ: begin
          if (!w_item.zeroed) begin
            gain_acc <= gain_acc + GAIN_W'(sq_diff);
          end
          if (position == LAST_POS) begin
            state <= ST_COST;
          end else begin
            position <= position + 1'b1;
            state    <= ST_EMIT;
          end
        end
        ST_COST: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (gain_acc > cost_ext) begin
            if (block_max > total_max) total_max <= block_max;
            if (block_min < total_min) total_min <= block_min;
            total_count <= cnt_sum[TOTAL_CNT_W] ? '1 : cnt_sum[TOTAL_CNT_W-1:0];
          end
          position  <= '0;
          gain_acc  <= '0;
          bits_acc  <= '0;
          nonzero   <= '0;
          block_max <= '0;
          block_min <= '0;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_ready) w_item <= item;
      end
      ST_ERR: begin
        w_err  <= err_w;
        w_code <= w_item.zeroed ? 16'd0 : code_w;
      end
      ST_SQ: begin
        rate     <= rate_w;
        w_end    <= (position == LAST_POS);
        res_gain <= '0;
        res_sig  <= 1'b0;
      end
      ST_COST: begin
        cost <= cfg.lambda * rate;
      end
      ST_DECIDE: begin
        if (gain_acc > cost_ext) begin
          res_sig  <= 1'b1;
          res_gain <= (net[GAIN_W-1:OUT_GAIN_W] != '0) ? '1 : net[OUT_GAIN_W-1:0];
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          code          <= w_code;
          block_end     <= w_end;
          block_gain    <= res_gain;
          significant   <= res_sig;
          running_max   <= total_max[14:0];
          running_min   <= total_min;
          running_count <= total_count;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ design/deadzone_quant_rd_block_core.sv @@
// top level of the dead-zone quantizer with per-block rate-distortion decision
// depends on dqrb_pkg, dqrb_front, dqrb_queue and dqrb_back
//
// Coefficients of 4x4 blocks arrive in raster order on the coef channel, one
// result per coefficient leaves on the result channel. The front end applies
// the dead zone and quantizes in the accepting cycle and drops the item into
// a queue of QUEUE_DEPTH entries; the back-end sequencer then computes the
// reconstruction error, accumulates gain and rate and, on the 16th
// coefficient, compares the gain with lambda times rate. The back end handles
// one item at a time: error and square steps for every coefficient, then
// cost and decision steps for the last one of a block, then the emit step.
// A finished result sits in an output register while the back end already
// works on the next queued item, and the front end keeps accepting until the
// queue fills. running_* reflect totals over significant blocks after the
// item; block_gain and significant are zero except on the block_end result.
// Configuration is written through cfg_write / cfg_index / cfg_data and must
// only change while the block is idle.
module deadzone_quant_rd_block_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [dqrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dqrb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // coefficient channel
  input  logic                              coef_valid,
  output logic                              coef_stall,
  input  logic signed [15:0]                coefficient,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [15:0]                       code,
  output logic                              block_end,
  output logic [31:0]                       block_gain,
  output logic                              significant,
  output logic [14:0]                       running_max,
  output logic signed [15:0]                running_min,
  output logic [23:0]                       running_count
);
  import dqrb_pkg::*;

  dqrb_cfg_t  cfg;
  dqrb_item_t front_item;
  dqrb_item_t head_item;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_not_empty;

  // configuration registers, unknown indices ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quant_step   <= 15'd1;
      cfg.inverse_step <= 15'd32767;
      cfg.dead_zone    <= 14'd0;
      cfg.lambda       <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_QUANT_STEP:   cfg.quant_step   <= cfg_data[14:0];
        REG_INVERSE_STEP: cfg.inverse_step <= cfg_data[14:0];
        REG_DEAD_ZONE:    cfg.dead_zone    <= cfg_data[13:0];
        REG_LAMBDA:       cfg.lambda       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // dead zone and quantization, accepted straight into the queue
  dqrb_front u_front (
    .coef_valid  (coef_valid),
    .coef_stall  (coef_stall),
    .coefficient (coefficient),
    .cfg         (cfg),
    .queue_full  (queue_full),
    .push        (push),
    .item        (front_item)
  );

  // decouples intake from the multi-cycle back end
  dqrb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head_item)
  );

  // accumulation, block decision and result register
  dqrb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_ready    (queue_not_empty),
    .item          (head_item),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .code          (code),
    .block_end     (block_end),
    .block_gain    (block_gain),
    .significant   (significant),
    .running_max   (running_max),
    .running_min   (running_min),
    .running_count (running_count)
  );
endmodule

@@ design/dqrb_checker.sv @@
// port-level checks for the dead-zone quantizer block
// no package dependency; bound to deadzone_quant_rd_block_core below
module dqrb_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic               block_end,
  input logic [31:0]        block_gain,
  input logic               significant,
  input logic signed [15:0] running_min,
  input logic [23:0]        running_count
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a decision only shows on the last coefficient of a block
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !block_end |-> !significant && (block_gain == 32'd0))
    else $error("decision outside block end");

  // significant blocks report a positive gain, others report zero
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (significant == (block_gain != 32'd0)))
    else $error("gain disagrees with significance");

  // running count and running minimum never move backward from one result to the next
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall |=>
      !result_valid || ((running_count >= $past(running_count)) &&
                        (running_min <= $past(running_min))))
    else $error("running totals went backward");

endmodule

bind deadzone_quant_rd_block_core dqrb_checker u_dqrb_checker (.*);
